@@ design/dac_pkg.sv @@
// Shared types and constants for the door access controller.
`default_nettype none
package dac_pkg;

   localparam int unsigned KEY_W       = 64;
   localparam int unsigned TIME_W      = 16;
   localparam int unsigned CSR_IDX_W   = 2;
   localparam int unsigned REQ_DATA_W  = 72;
   localparam int unsigned RSP_DATA_W  = 16;

   localparam int unsigned IDLE_TIMEOUT_DEFAULT = 30000;
   localparam logic [TIME_W-1:0] OPEN_TIME_RESET = 16'd3000;

   typedef enum logic [2:0] {
      OP_KEY         = 3'd0,
      OP_BUTTON      = 3'd1,
      OP_TICK        = 3'd2,
      OP_LOG_FULL    = 3'd3,
      OP_LOG_CLEARED = 3'd4
   } op_type;

   typedef enum logic [2:0] {
      MODE_IDLE     = 3'd0,
      MODE_TIMED    = 3'd1,
      MODE_BISTABLE = 3'd2,
      MODE_SAME_KEY = 3'd3,
      MODE_SUPER    = 3'd4,
      MODE_LOCKOUT  = 3'd5
   } mode_type;

   typedef enum logic [2:0] {
      EV_GRANTED,
      EV_SUPER,
      EV_INVALID,
      EV_BUTTON,
      EV_TIMEOUT,
      EV_NONE
   } ev_type;

   localparam logic [2:0] PATTERN_GREEN = 3'd0;
   localparam logic [2:0] PATTERN_BOTH  = 3'd2;
   localparam logic [2:0] PATTERN_OFF   = 3'd4;

   localparam logic [1:0] OPEN_BISTABLE = 2'd1;
   localparam logic [1:0] OPEN_SAME_KEY = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_OPEN_MODE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OPEN_TIME = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SU_KEY    = 2'd2;

   typedef struct packed {
      logic              superuser_enable_pin;
      logic              key_authorized;
      logic [KEY_W-1:0]  key_code;
      logic [2:0]        op;
   } item_type;

   typedef struct packed {
      logic       reject_pulse;
      logic       clear_log_request;
      logic [2:0] mode_state;
      logic [2:0] blink_pattern;
      logic       green_led;
      logic       red_led;
      logic       relay_on;
   } rsp_type;

endpackage
`default_nettype wire

@@ design/dac_core.sv @@
// Mode state machine, timeout counter, key latches and setting registers.
`default_nettype none
module dac_core #(
   parameter int unsigned IDLE_TIMEOUT_TICKS = dac_pkg::IDLE_TIMEOUT_DEFAULT
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           fire,
   input  wire dac_pkg::item_type              item,
   input  wire logic                           csr_we,
   input  wire logic [dac_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [dac_pkg::KEY_W-1:0]      csr_wdata,
   output dac_pkg::rsp_type                    rsp
);
   import dac_pkg::*;

   localparam logic [TIME_W-1:0] IDLE_TICKS = TIME_W'(IDLE_TIMEOUT_TICKS);

   logic [1:0]        open_mode_ff;
   logic [TIME_W-1:0] open_time_ff;
   logic [KEY_W-1:0]  su_key_ff;

   mode_type          mode_ff, mode_in;
   logic [TIME_W-1:0] cnt_ff, cnt_in;
   logic              run_ff, run_in;
   logic              relay_ff, relay_in;
   logic              red_ff, red_in;
   logic              green_ff, green_in;
   logic [2:0]        blink_ff, blink_in;
   logic [KEY_W-1:0]  lgk_ff, lgk_in;
   logic [KEY_W-1:0]  opk_ff, opk_in;

   ev_type            ev;
   logic              open_req, close_req, clr, rej;

   always_ff @(posedge clock) begin
      if (reset) begin
         open_mode_ff <= 2'd0;
         open_time_ff <= OPEN_TIME_RESET;
         su_key_ff    <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_OPEN_MODE: open_mode_ff <= csr_wdata[1:0];
            CSR_OPEN_TIME: open_time_ff <= csr_wdata[TIME_W-1:0];
            CSR_SU_KEY:    su_key_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         cnt_ff   <= '0;
         run_ff   <= 1'b0;
         relay_ff <= 1'b0;
         red_ff   <= 1'b1;
         green_ff <= 1'b0;
         blink_ff <= PATTERN_OFF;
         lgk_ff   <= '0;
         opk_ff   <= '0;
      end else if (fire) begin
         mode_ff  <= mode_in;
         cnt_ff   <= cnt_in;
         run_ff   <= run_in;
         relay_ff <= relay_in;
         red_ff   <= red_in;
         green_ff <= green_in;
         blink_ff <= blink_in;
         lgk_ff   <= lgk_in;
         opk_ff   <= opk_in;
      end
   end

   always_comb begin
      mode_in   = mode_ff;
      cnt_in    = cnt_ff;
      run_in    = run_ff;
      relay_in  = relay_ff;
      red_in    = red_ff;
      green_in  = green_ff;
      blink_in  = blink_ff;
      lgk_in    = lgk_ff;
      opk_in    = opk_ff;
      ev        = EV_NONE;
      open_req  = 1'b0;
      close_req = 1'b0;
      clr       = 1'b0;
      rej       = 1'b0;

      unique case (item.op)
         OP_KEY: begin
            if (item.key_authorized && mode_ff != MODE_LOCKOUT) begin
               lgk_in = item.key_code;
               ev     = EV_GRANTED;
            end else if (item.key_code == su_key_ff) begin
               ev = EV_SUPER;
            end else begin
               ev = EV_INVALID;
            end
         end
         OP_BUTTON: ev = EV_BUTTON;
         OP_TICK: begin
            if (run_ff) begin
               if (cnt_ff <= TIME_W'(1)) begin
                  cnt_in = '0;
                  run_in = 1'b0;
                  ev     = EV_TIMEOUT;
               end else begin
                  cnt_in = cnt_ff - TIME_W'(1);
               end
            end
         end
         OP_LOG_FULL: begin
            relay_in = 1'b0;
            red_in   = 1'b1;
            green_in = 1'b1;
            blink_in = PATTERN_BOTH;
            cnt_in   = IDLE_TICKS;
            run_in   = 1'b1;
            mode_in  = MODE_LOCKOUT;
         end
         OP_LOG_CLEARED: begin
            red_in   = 1'b1;
            green_in = 1'b0;
            mode_in  = MODE_IDLE;
         end
         default: ;
      endcase

      unique case (mode_ff)
         MODE_IDLE: begin
            if (ev == EV_SUPER && item.superuser_enable_pin) begin
               blink_in = PATTERN_GREEN;
               cnt_in   = IDLE_TICKS;
               run_in   = 1'b1;
               mode_in  = MODE_SUPER;
            end else if (ev == EV_SUPER || ev == EV_GRANTED) begin
               open_req = 1'b1;
            end else if (ev == EV_INVALID) begin
               red_in   = 1'b1;
               green_in = 1'b0;
               rej      = 1'b1;
            end else if (ev == EV_BUTTON && open_mode_ff != OPEN_BISTABLE
                         && open_mode_ff != OPEN_SAME_KEY) begin
               open_req = 1'b1;
            end
         end
         MODE_TIMED:    close_req = (ev == EV_TIMEOUT);
         MODE_BISTABLE: close_req = (ev == EV_GRANTED);
         MODE_SAME_KEY: close_req = (ev == EV_GRANTED) && (lgk_in == opk_ff);
         MODE_SUPER: begin
            if (ev == EV_TIMEOUT) begin
               blink_in = PATTERN_OFF;
               cnt_in   = IDLE_TICKS;
               run_in   = 1'b1;
               mode_in  = MODE_IDLE;
            end
         end
         MODE_LOCKOUT: begin
            if (ev == EV_SUPER) begin
               red_in   = 1'b1;
               green_in = 1'b0;
               mode_in  = MODE_IDLE;
               clr      = 1'b1;
            end else if (ev == EV_BUTTON) begin
               relay_in = 1'b1;
               cnt_in   = open_time_ff;
               run_in   = 1'b1;
            end else if (ev == EV_TIMEOUT) begin
               relay_in = 1'b0;
            end
         end
         default: ;
      endcase

      if (open_req) begin
         red_in   = 1'b0;
         green_in = 1'b1;
         relay_in = 1'b1;
         priority if (open_mode_ff == OPEN_BISTABLE) begin
            mode_in = MODE_BISTABLE;
         end else if (open_mode_ff == OPEN_SAME_KEY) begin
            opk_in  = lgk_in;
            mode_in = MODE_SAME_KEY;
         end else begin
            cnt_in  = open_time_ff;
            run_in  = 1'b1;
            mode_in = MODE_TIMED;
         end
      end

      if (close_req) begin
         red_in   = 1'b1;
         green_in = 1'b0;
         relay_in = 1'b0;
         blink_in = PATTERN_OFF;
         cnt_in   = IDLE_TICKS;
         run_in   = 1'b1;
         mode_in  = MODE_IDLE;
      end
   end

   assign rsp.relay_on          = relay_in;
   assign rsp.red_led           = red_in;
   assign rsp.green_led         = green_in;
   assign rsp.blink_pattern     = blink_in;
   assign rsp.mode_state        = mode_in;
   assign rsp.clear_log_request = clr;
   assign rsp.reject_pulse      = rej;

`ifndef SYNTH
   // both LEDs lit only while the log is full
   a_both_leds_lockout: assert property (@(posedge clock) disable iff (reset)
      (red_ff && green_ff) |-> (mode_ff == MODE_LOCKOUT))
      else $error("both LEDs lit outside lockout");

   a_reject_idle: assert property (@(posedge clock) disable iff (reset)
      (fire && rej) |-> (mode_ff == MODE_IDLE))
      else $error("reject outside idle");

   a_clear_to_idle: assert property (@(posedge clock) disable iff (reset)
      (fire && clr) |=> (mode_ff == MODE_IDLE))
      else $error("log clear request without return to idle");

   a_log_full: assert property (@(posedge clock) disable iff (reset)
      (fire && item.op == OP_LOG_FULL) |=> (!relay_ff && mode_ff == MODE_LOCKOUT))
      else $error("log full did not lock out");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      !fire |=> ($stable(mode_ff) && $stable(cnt_ff) && $stable(relay_ff)))
      else $error("state moved without an item");
`endif
endmodule
`default_nettype wire

@@ design/door_access_controller_fsm.sv @@
// Door access controller: item input register, control core, result register.
//
// Usage:
//   req_* takes one event item per handshake: tuser carries the event kind,
//   tdata the key code, the database verdict and the superuser pin level.
//   rsp_* returns exactly one item per event, showing the relay, LEDs, blink
//   code, mode and the log-clear and reject pulses after that event.
//   csr_* writes the open mode, open time and superuser key; write only
//   while no item is in flight.
// Path: the input register loads at acceptance, the result register loads when
//   the core fires, and rsp_tvalid rises from the result register.
// Throughput: one item per cycle while rsp_tready holds; each event is one update
//   of the mode register and timeout counter.
// Reset: synchronous; idle mode, relay off, red on, blink none, timer stopped,
//   settings back to timed mode, 3000 ticks and a zero superuser key.
// Stall: a held result keeps the result register; one further item waits in
//   the input register, then req_tready drops until rsp_tready returns.
`default_nettype none
module door_access_controller_fsm #(
   parameter int unsigned IDLE_TIMEOUT_TICKS = dac_pkg::IDLE_TIMEOUT_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output      logic                            req_tready,
   // key_code[63:0], key_authorized[64], superuser_enable_pin[65], zero pad
   input  wire logic [dac_pkg::REQ_DATA_W-1:0]  req_tdata,
   // op[2:0]
   input  wire logic [2:0]                      req_tuser,
   output      logic                            rsp_tvalid,
   input  wire logic                            rsp_tready,
   // relay_on[0], red_led[1], green_led[2], blink_pattern[5:3],
   // mode_state[8:6], clear_log_request[9], reject_pulse[10], zero pad
   output      logic [dac_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  wire logic                            csr_we,
   input  wire logic [dac_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [dac_pkg::KEY_W-1:0]       csr_wdata
);
   import dac_pkg::*;

   logic     in_valid_ff;
   item_type item_ff;
   logic     rsp_valid_ff;
   rsp_type  rsp_ff;
   rsp_type  rsp_in;
   logic     out_ready, fire;

   assign out_ready  = !rsp_valid_ff || rsp_tready;
   assign fire       = in_valid_ff && out_ready;
   assign req_tready = !in_valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         item_ff.op                   <= req_tuser;
         item_ff.key_code             <= req_tdata[KEY_W-1:0];
         item_ff.key_authorized       <= req_tdata[KEY_W];
         item_ff.superuser_enable_pin <= req_tdata[KEY_W+1];
      end
   end

   dac_core #(
      .IDLE_TIMEOUT_TICKS(IDLE_TIMEOUT_TICKS)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .fire     (fire),
      .item     (item_ff),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .rsp      (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_W - $bits(rsp_type))'(0), rsp_ff};
endmodule
`default_nettype wire

@@ tb/sv/door_access_checker.sv @@
// Checker for the door access controller: predicts each result item and compares it.
module door_access_checker #(
   parameter int unsigned IDLE_TICKS = dac_pkg::IDLE_TIMEOUT_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [dac_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic [2:0]                      req_tuser,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [dac_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                            csr_we,
   input  logic [dac_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [dac_pkg::KEY_W-1:0]       csr_wdata,
   output int                              outstanding,
   output int                              mismatches,
   output int                              results_checked
);
   import dac_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic [1:0]        cfg_open_mode;
   logic [TIME_W-1:0] cfg_open_time;
   logic [KEY_W-1:0]  cfg_su_key;

   mode_type          door_mode;
   logic [TIME_W-1:0] tmo_count;
   logic              tmo_run;
   logic              relay;
   logic              red;
   logic              green;
   logic [2:0]        blink;
   logic [KEY_W-1:0]  granted_key;
   logic [KEY_W-1:0]  opener_key;
   logic              pulse_clr;
   logic              pulse_rej;

   rsp_type           outputs_due[$];

   function automatic void load_timer(logic [TIME_W-1:0] ticks);
      tmo_count = ticks;
      tmo_run = 1'b1;
   endfunction

   function automatic void show_blink(logic [2:0] code);
      blink = code;
      load_timer(TIME_W'(IDLE_TICKS));
   endfunction

   function automatic void close_door();
      red = 1'b1;
      green = 1'b0;
      relay = 1'b0;
      show_blink(PATTERN_OFF);
      door_mode = MODE_IDLE;
   endfunction

   function automatic void open_door();
      red = 1'b0;
      green = 1'b1;
      relay = 1'b1;
      if (cfg_open_mode == OPEN_BISTABLE) begin
         door_mode = MODE_BISTABLE;
      end else if (cfg_open_mode == OPEN_SAME_KEY) begin
         opener_key = granted_key;
         door_mode = MODE_SAME_KEY;
      end else begin
         load_timer(cfg_open_time);
         door_mode = MODE_TIMED;
      end
   endfunction

   function automatic void handle_event(ev_type ev, logic pin);
      case (door_mode)
         MODE_IDLE: begin
            if (ev == EV_SUPER && pin) begin
               show_blink(PATTERN_GREEN);
               door_mode = MODE_SUPER;
            end else if (ev == EV_SUPER || ev == EV_GRANTED) begin
               open_door();
            end else if (ev == EV_INVALID) begin
               red = 1'b1;
               green = 1'b0;
               pulse_rej = 1'b1;
            end else if (ev == EV_BUTTON && cfg_open_mode != OPEN_BISTABLE
                         && cfg_open_mode != OPEN_SAME_KEY) begin
               open_door();
            end
         end
         MODE_TIMED: begin
            if (ev == EV_TIMEOUT) close_door();
         end
         MODE_BISTABLE: begin
            if (ev == EV_GRANTED) close_door();
         end
         MODE_SAME_KEY: begin
            if (ev == EV_GRANTED && granted_key == opener_key) close_door();
         end
         MODE_SUPER: begin
            if (ev == EV_TIMEOUT) begin
               show_blink(PATTERN_OFF);
               door_mode = MODE_IDLE;
            end
         end
         MODE_LOCKOUT: begin
            if (ev == EV_SUPER) begin
               red = 1'b1;
               green = 1'b0;
               door_mode = MODE_IDLE;
               pulse_clr = 1'b1;
            end else if (ev == EV_BUTTON) begin
               relay = 1'b1;
               load_timer(cfg_open_time);
            end else if (ev == EV_TIMEOUT) begin
               relay = 1'b0;
            end
         end
         default: ;
      endcase
   endfunction

   function automatic rsp_type door_step(item_type it);
      rsp_type r;
      pulse_clr = 1'b0;
      pulse_rej = 1'b0;
      case (it.op)
         OP_KEY: begin
            if (it.key_authorized && door_mode != MODE_LOCKOUT) begin
               granted_key = it.key_code;
               handle_event(EV_GRANTED, it.superuser_enable_pin);
            end else if (it.key_code == cfg_su_key) begin
               handle_event(EV_SUPER, it.superuser_enable_pin);
            end else begin
               handle_event(EV_INVALID, it.superuser_enable_pin);
            end
         end
         OP_BUTTON: handle_event(EV_BUTTON, it.superuser_enable_pin);
         OP_TICK: begin
            if (tmo_run) begin
               if (tmo_count <= TIME_W'(1)) begin
                  tmo_count = '0;
                  tmo_run = 1'b0;
                  handle_event(EV_TIMEOUT, it.superuser_enable_pin);
               end else begin
                  tmo_count = tmo_count - TIME_W'(1);
               end
            end
         end
         OP_LOG_FULL: begin
            relay = 1'b0;
            red = 1'b1;
            green = 1'b1;
            show_blink(PATTERN_BOTH);
            door_mode = MODE_LOCKOUT;
         end
         OP_LOG_CLEARED: begin
            red = 1'b1;
            green = 1'b0;
            door_mode = MODE_IDLE;
         end
         default: ;
      endcase
      r.relay_on = relay;
      r.red_led = red;
      r.green_led = green;
      r.blink_pattern = blink;
      r.mode_state = door_mode;
      r.clear_log_request = pulse_clr;
      r.reject_pulse = pulse_rej;
      return r;
   endfunction

   function automatic void check_field(string name, logic [2:0] want, logic [2:0] got);
      if (got !== want) begin
         if (mismatches < 50)
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      item_type it;
      rsp_type  got;
      rsp_type  want;
      if (reset) begin
         cfg_open_mode = '0;
         cfg_open_time = OPEN_TIME_RESET;
         cfg_su_key = '0;
         door_mode = MODE_IDLE;
         tmo_count = '0;
         tmo_run = 1'b0;
         relay = 1'b0;
         red = 1'b1;
         green = 1'b0;
         blink = PATTERN_OFF;
         granted_key = '0;
         opener_key = '0;
         outputs_due.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_OPEN_MODE: cfg_open_mode = csr_wdata[1:0];
               CSR_OPEN_TIME: cfg_open_time = csr_wdata[TIME_W-1:0];
               CSR_SU_KEY:    cfg_su_key = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_type'(rsp_tdata[$bits(rsp_type)-1:0]);
            if (outputs_due.size() == 0) begin
               if (mismatches < 50)
                  $display("%0t ns: unexpected result, expected none, got %h", $time, rsp_tdata);
               mismatches++;
            end else begin
               want = outputs_due.pop_front();
               check_field("relay_on", 3'(want.relay_on), 3'(got.relay_on));
               check_field("red_led", 3'(want.red_led), 3'(got.red_led));
               check_field("green_led", 3'(want.green_led), 3'(got.green_led));
               check_field("blink_pattern", want.blink_pattern, got.blink_pattern);
               check_field("mode_state", want.mode_state, got.mode_state);
               check_field("clear_log_request", 3'(want.clear_log_request),
                           3'(got.clear_log_request));
               check_field("reject_pulse", 3'(want.reject_pulse), 3'(got.reject_pulse));
               results_checked++;
            end
         end
         if (req_tvalid && req_tready) begin
            it = {req_tdata[KEY_W+1], req_tdata[KEY_W], req_tdata[KEY_W-1:0], req_tuser};
            outputs_due.push_back(door_step(it));
         end
      end
      outstanding <= outputs_due.size();
   end

endmodule

@@ tb/sv/tb_top.sv @@
// Top-level testbench for the door access controller: stimulus, idling and verdict.
module tb_top;
   import dac_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned SETTLE_CYCLES = 6;
   localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;
   localparam logic [2:0] OP_UNUSED_LAST = 3'd7;
   localparam logic [1:0] OPEN_TIMED = 2'd0;
   localparam logic [1:0] OPEN_SPARE = 2'd3;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   // key_code[63:0], key_authorized[64], superuser_enable_pin[65], zero pad
   logic [REQ_DATA_W-1:0]  req_tdata;
   // op[2:0]
   logic [2:0]             req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   // relay_on[0], red_led[1], green_led[2], blink_pattern[5:3],
   // mode_state[8:6], clear_log_request[9], reject_pulse[10], zero pad
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   csr_we;
   logic [CSR_IDX_W-1:0]   csr_index;
   logic [KEY_W-1:0]       csr_wdata;

   int                     outstanding;
   int                     mismatches;
   int                     results_checked;

   bit                     gaps_on;
   int                     cycle_count;
   int                     settings_used;
   int                     op_tally[8];
   logic [KEY_W-1:0]       key_pool[4];

   door_access_controller_fsm dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   door_access_checker checker_i (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .outstanding     (outstanding),
      .mismatches      (mismatches),
      .results_checked (results_checked)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_top: timed out after %0d cycles", cycle_count);
         $display("tb_top: FAIL");
         $finish;
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      else if (r < 95) return $urandom_range(1, 3);
      else return $urandom_range(8, 40);
   endfunction

   function automatic logic [KEY_W-1:0] rand_key();
      return {$urandom, $urandom};
   endfunction

   function automatic logic rand_bit();
      return 1'($urandom_range(0, 1));
   endfunction

   task automatic send_item(logic [2:0] op, logic [KEY_W-1:0] key, logic auth, logic pin);
      int gap;
      gap = gaps_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= REQ_DATA_W'({pin, auth, key});
      req_tuser <= op;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      op_tally[op]++;
   endtask

   // hold off until every predicted item has come back, then let the bench settle
   task automatic wait_quiet();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_config(logic [1:0] mode, logic [TIME_W-1:0] ticks, logic [KEY_W-1:0] su);
      csr_we <= 1'b1;
      csr_index <= CSR_OPEN_MODE;
      csr_wdata <= KEY_W'(mode);
      @(posedge clock);
      csr_index <= CSR_OPEN_TIME;
      csr_wdata <= KEY_W'(ticks);
      @(posedge clock);
      csr_index <= CSR_SU_KEY;
      csr_wdata <= su;
      @(posedge clock);
      csr_we <= 1'b0;
      key_pool[0] = su;
      for (int i = 1; i < 4; i++) key_pool[i] = rand_key();
      settings_used++;
   endtask

   task automatic send_random_item();
      int r;
      logic [KEY_W-1:0] k;
      r = $urandom_range(0, 99);
      if (r < 38) begin
         k = ($urandom_range(0, 4) == 0) ? rand_key() : key_pool[$urandom_range(0, 3)];
         send_item(OP_KEY, k, $urandom_range(0, 99) < 60, rand_bit());
      end else if (r < 48) begin
         send_item(OP_BUTTON, rand_key(), rand_bit(), rand_bit());
      end else if (r < 88) begin
         repeat ($urandom_range(1, 6))
            send_item(OP_TICK, rand_key(), rand_bit(), rand_bit());
      end else if (r < 93) begin
         send_item(OP_LOG_FULL, rand_key(), rand_bit(), rand_bit());
      end else if (r < 98) begin
         send_item(OP_LOG_CLEARED, rand_key(), rand_bit(), rand_bit());
      end else begin
         send_item(3'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST)), rand_key(),
                   rand_bit(), rand_bit());
      end
   endtask

   initial begin
      logic [KEY_W-1:0] key_a;
      logic [TIME_W-1:0] ticks;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      gaps_on = 1'b1;
      settings_used = 0;
      foreach (op_tally[i]) op_tally[i] = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: timed mode, open time of one tick, all-ones superuser key
      set_config(OPEN_TIMED, 16'd1, '1);
      send_item(OP_KEY, '0, 1'b0, 1'b0);
      send_item(OP_KEY, '1, 1'b0, 1'b1);
      send_item(OP_LOG_FULL, rand_key(), 1'b0, 1'b0);
      send_item(OP_BUTTON, rand_key(), 1'b1, 1'b1);
      send_item(OP_TICK, rand_key(), 1'b0, 1'b0);
      send_item(OP_KEY, {32{2'b01}}, 1'b1, 1'b0);
      send_item(OP_KEY, '1, 1'b0, 1'b0);
      send_item(OP_KEY, '1, 1'b1, 1'b1);
      send_item(OP_TICK, rand_key(), 1'b1, 1'b0);
      send_item(OP_BUTTON, rand_key(), 1'b0, 1'b0);
      send_item(OP_LOG_CLEARED, rand_key(), 1'b1, 1'b1);
      send_item(OP_UNUSED_FIRST, rand_key(), 1'b1, 1'b1);
      send_item(OP_UNUSED_FIRST + 3'd1, rand_key(), 1'b0, 1'b1);
      send_item(OP_UNUSED_LAST, rand_key(), 1'b1, 1'b0);
      send_item(OP_KEY, {32{2'b10}}, 1'b0, 1'b1);
      wait_quiet();

      // bistable, zero open time, zero superuser key
      set_config(OPEN_BISTABLE, 16'd0, '0);
      send_item(OP_KEY, '0, 1'b0, 1'b0);
      send_item(OP_BUTTON, rand_key(), 1'b0, 1'b0);
      send_item(OP_KEY, rand_key(), 1'b1, 1'b0);
      send_item(OP_BUTTON, rand_key(), 1'b0, 1'b1);
      wait_quiet();

      // same-key, longest open time
      set_config(OPEN_SAME_KEY, 16'hFFFF, rand_key());
      key_a = rand_key();
      send_item(OP_KEY, key_a, 1'b1, 1'b0);
      send_item(OP_KEY, ~key_a, 1'b1, 1'b1);
      send_item(OP_KEY, key_a, 1'b1, 1'b0);
      wait_quiet();

      // spare open mode acts as timed
      set_config(OPEN_SPARE, 16'd0, rand_key());
      send_item(OP_BUTTON, rand_key(), 1'b0, 1'b0);
      send_item(OP_TICK, rand_key(), 1'b0, 1'b0);

      // superuser mode entered from idle, then a few ticks back to back
      gaps_on = 1'b0;
      send_item(OP_LOG_CLEARED, rand_key(), 1'b0, 1'b0);
      send_item(OP_KEY, key_pool[0], 1'b0, 1'b1);
      repeat (4)
         send_item(OP_TICK, rand_key(), rand_bit(), rand_bit());
      gaps_on = 1'b1;
      wait_quiet();

      // random phases across settings
      for (int phase = 0; phase < 5; phase++) begin
         case ($urandom_range(0, 9))
            0: ticks = 16'd0;
            1: ticks = 16'hFFFF;
            default: ticks = TIME_W'($urandom_range(1, 6));
         endcase
         set_config(phase < 4 ? phase[1:0] : 2'($urandom_range(0, 3)), ticks, rand_key());
         gaps_on = (phase != 2);
         for (int n = 0; n < 40; n++) begin
            send_random_item();
            if ($urandom_range(0, 49) == 0) wait_quiet();
         end
         wait_quiet();
      end
      gaps_on = 1'b1;

      wait_quiet();
      $display("tb_top: %0d key touches, %0d buttons, %0d ticks, %0d log-full, %0d log-cleared,",
               op_tally[OP_KEY], op_tally[OP_BUTTON], op_tally[OP_TICK],
               op_tally[OP_LOG_FULL], op_tally[OP_LOG_CLEARED]);
      $display("tb_top: %0d unused ops over %0d settings; %0d results checked",
               op_tally[5] + op_tally[6] + op_tally[7], settings_used, results_checked);
      if (mismatches == 0 && outstanding == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

   // result side: runs of ready with random stalls between them
   initial begin
      wait (reset === 1'b0);
      forever begin
         int g;
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 24)) @(posedge clock);
         g = gaps_on ? pick_gap() : 0;
         if (g > 0) begin
            rsp_tready <= 1'b0;
            repeat (g) @(posedge clock);
         end
      end
   end

endmodule
